/* src/dvdp_pkg.sv */
// Shared kind codes and term type for the dependence vector dot product.
package dvdp_pkg;

    localparam logic [2:0] KIND_EQ    = 3'd0;
    localparam logic [2:0] KIND_LT    = 3'd1;
    localparam logic [2:0] KIND_GT    = 3'd2;
    localparam logic [2:0] KIND_LEQ   = 3'd3;
    localparam logic [2:0] KIND_GEQ   = 3'd4;
    localparam logic [2:0] KIND_STAR  = 3'd5;
    localparam logic [2:0] KIND_EXACT = 3'd6;

    localparam int KIND_W     = 3;
    localparam int DIST_OUT_W = 32;
    localparam int COEF_W     = 16;
    // result_kind and result_distance padded to whole bytes
    localparam int OUT_TDATA_W = ((KIND_W + DIST_OUT_W + 7) / 8) * 8;

    typedef struct packed {
        logic [KIND_W-1:0]            kind;
        logic signed [DIST_OUT_W-1:0] distance;
    } term_t;

endpackage

/* src/dependence_vector_dot_product.sv */
// Top level: folds a dependence vector with a transformation row, one element a beat.
//
//  Channel | Dir | Beat contents
//  --------+-----+---------------------------------------------------------
//  s_axis  | in  | tdata: dep_dir, dep_dist, coef; tlast: last element
//  m_axis  | out | tdata: result_kind, result_distance (one beat per vector)
//
// One element a cycle unless a last element is held back: a beat lands in the
// input register, and in the next cycle the scaled term is formed and merged
// into the running kind and distance; the multiply, 33-bit add and lattice
// are combinational between the two. A result is registered when its last element leaves the input register.
// Reset sets the fold to exact distance zero and empties both registers.
// A full, unread result register holds back only a last element; other
// elements keep folding while the result waits.
module dependence_vector_dot_product #(
    parameter int DIST_WIDTH = 16
) (
    input  logic clk,
    input  logic rst_n,

    input  logic s_axis_tvalid,
    output logic s_axis_tready,
    // bits from 0 up: dep_dir[3], dep_dist[DIST_WIDTH], coef[16], zero pad
    input  logic [((DIST_WIDTH + 19 + 7) / 8) * 8 - 1:0] s_axis_tdata,
    input  logic s_axis_tlast,

    output logic m_axis_tvalid,
    input  logic m_axis_tready,
    // bits from 0 up: result_kind[3], result_distance[32], zero pad
    output logic [dvdp_pkg::OUT_TDATA_W-1:0] m_axis_tdata
);

    // input register
    logic                         in_valid_reg, in_valid_next;
    logic [2:0]                   in_dir_reg;
    logic signed [DIST_WIDTH-1:0] in_dist_reg;
    logic signed [15:0]           in_coef_reg;
    logic                         in_last_reg;
    logic                         in_take;
    logic                         in_go;

    // running fold
    logic [2:0]         run_kind_reg, run_kind_next;
    logic signed [31:0] run_dist_reg, run_dist_next;
    logic [2:0]         merge_kind;
    logic signed [31:0] merge_dist;
    logic signed [32:0] sum;
    logic signed [31:0] sum_sat;

    // result register
    logic                  out_valid_reg, out_valid_next;
    dvdp_pkg::term_t       out_reg;
    logic                  out_load;

    dvdp_pkg::term_t       term;

    // A last element may move on only when the result register is free
    // or being emptied in this cycle.
    assign in_go   = in_valid_reg && (!in_last_reg || !out_valid_reg || m_axis_tready);
    assign out_load = in_go && in_last_reg;
    assign in_take = s_axis_tvalid && s_axis_tready;
    assign s_axis_tready = !in_valid_reg || in_go;

    always_comb
    begin
        in_valid_next = in_valid_reg;
        if (in_take) begin
            in_valid_next = 1'b1;
        end else if (in_go) begin
            in_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            in_valid_reg <= 1'b0;
        end else begin
            in_valid_reg <= in_valid_next;
        end
    end

    // capture the fields of an accepted beat; padding bits are dropped
    always_ff @(posedge clk)
    begin
        if (in_take) begin
            in_dir_reg  <= s_axis_tdata[2:0];
            in_dist_reg <= s_axis_tdata[3 +: DIST_WIDTH];
            in_coef_reg <= s_axis_tdata[3 + DIST_WIDTH +: 16];
            in_last_reg <= s_axis_tlast;
        end
    end

    dvdp_term #(
        .DIST_WIDTH (DIST_WIDTH)
    ) u_term (
        .dep_dir  (in_dir_reg),
        .dep_dist (in_dist_reg),
        .coef     (in_coef_reg),
        .term     (term)
    );

    // running sum of exact distances, clamped to the signed 32-bit range
    assign sum = 33'(run_dist_reg) + 33'(term.distance);
    always_comb
    begin
        if (sum[32] == sum[31]) begin
            sum_sat = sum[31:0];
        end else if (sum[32]) begin
            sum_sat = 32'sh8000_0000;
        end else begin
            sum_sat = 32'sh7fff_ffff;
        end
    end

    // Direction lattice: eq is neutral, star absorbs, exact distances add,
    // and a signed distance can tighten leq/geq or contradict lt/gt.
    always_comb
    begin
        merge_kind = run_kind_reg;
        merge_dist = run_dist_reg;
        unique case (run_kind_reg)
            dvdp_pkg::KIND_LT:
            begin
                if (term.kind == dvdp_pkg::KIND_EXACT) begin
                    if (term.distance < 0) merge_kind = dvdp_pkg::KIND_STAR;
                end else if (term.kind == dvdp_pkg::KIND_GT || term.kind == dvdp_pkg::KIND_GEQ
                             || term.kind == dvdp_pkg::KIND_STAR) begin
                    merge_kind = dvdp_pkg::KIND_STAR;
                end
            end
            dvdp_pkg::KIND_GT:
            begin
                if (term.kind == dvdp_pkg::KIND_EXACT) begin
                    if (term.distance > 0) merge_kind = dvdp_pkg::KIND_STAR;
                end else if (term.kind == dvdp_pkg::KIND_LT || term.kind == dvdp_pkg::KIND_LEQ
                             || term.kind == dvdp_pkg::KIND_STAR) begin
                    merge_kind = dvdp_pkg::KIND_STAR;
                end
            end
            dvdp_pkg::KIND_LEQ:
            begin
                if (term.kind == dvdp_pkg::KIND_LT) begin
                    merge_kind = dvdp_pkg::KIND_LT;
                end else if (term.kind == dvdp_pkg::KIND_EXACT) begin
                    if (term.distance > 0) begin
                        merge_kind = dvdp_pkg::KIND_STAR;
                    end else if (term.distance < 0) begin
                        merge_kind = dvdp_pkg::KIND_LT;
                    end
                end else if (term.kind == dvdp_pkg::KIND_GT || term.kind == dvdp_pkg::KIND_GEQ
                             || term.kind == dvdp_pkg::KIND_STAR) begin
                    merge_kind = dvdp_pkg::KIND_STAR;
                end
            end
            dvdp_pkg::KIND_GEQ:
            begin
                if (term.kind == dvdp_pkg::KIND_GT) begin
                    merge_kind = dvdp_pkg::KIND_GT;
                end else if (term.kind == dvdp_pkg::KIND_EXACT) begin
                    if (term.distance < 0) begin
                        merge_kind = dvdp_pkg::KIND_STAR;
                    end else if (term.distance > 0) begin
                        merge_kind = dvdp_pkg::KIND_GT;
                    end
                end else if (term.kind == dvdp_pkg::KIND_LT || term.kind == dvdp_pkg::KIND_LEQ
                             || term.kind == dvdp_pkg::KIND_STAR) begin
                    merge_kind = dvdp_pkg::KIND_STAR;
                end
            end
            dvdp_pkg::KIND_EXACT:
            begin
                if (term.kind == dvdp_pkg::KIND_EXACT) begin
                    merge_dist = sum_sat;
                end else if (term.kind != dvdp_pkg::KIND_EQ) begin
                    merge_kind = term.kind;
                    merge_dist = '0;
                end
            end
            dvdp_pkg::KIND_EQ:
            begin
                merge_kind = term.kind;
                merge_dist = (term.kind == dvdp_pkg::KIND_EXACT) ? term.distance : '0;
            end
            default:
            begin
                merge_kind = dvdp_pkg::KIND_STAR;
            end
        endcase
    end

    // advance the fold on every element that moves on but a last one, which restarts it
    always_comb
    begin
        run_kind_next = run_kind_reg;
        run_dist_next = run_dist_reg;
        if (in_go) begin
            if (in_last_reg) begin
                run_kind_next = dvdp_pkg::KIND_EXACT;
                run_dist_next = '0;
            end else begin
                run_kind_next = merge_kind;
                run_dist_next = merge_dist;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            run_kind_reg <= dvdp_pkg::KIND_EXACT;
            run_dist_reg <= '0;
        end else begin
            run_kind_reg <= run_kind_next;
            run_dist_reg <= run_dist_next;
        end
    end

    // result register: load on a last element, drop once the beat is taken
    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (out_load) begin
            out_valid_next = 1'b1;
        end else if (m_axis_tready) begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            out_valid_reg <= 1'b0;
        end else begin
            out_valid_reg <= out_valid_next;
        end
    end

    // a direction kind reports distance zero
    always_ff @(posedge clk)
    begin
        if (out_load) begin
            out_reg.kind     <= merge_kind;
            out_reg.distance <= (merge_kind == dvdp_pkg::KIND_EXACT) ? merge_dist : '0;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = dvdp_pkg::OUT_TDATA_W'({out_reg.distance, out_reg.kind});

endmodule

/* src/dvdp_term.sv */
// Element product: one dependence element scaled by one row coefficient.
module dvdp_term #(
    parameter int DIST_WIDTH = 16
) (
    input  logic [2:0]                   dep_dir,
    input  logic signed [DIST_WIDTH-1:0] dep_dist,
    input  logic signed [15:0]           coef,
    output dvdp_pkg::term_t              term
);

    localparam int PROD_W = DIST_WIDTH + dvdp_pkg::COEF_W;

    logic signed [PROD_W-1:0] prod;
    logic signed [31:0]       prod_sat;
    logic [2:0]               kind_in;

    assign prod = PROD_W'(dep_dist) * PROD_W'(coef);

    generate
        if (PROD_W > 32) begin : g_sat
            logic [PROD_W-32:0] upper;
            assign upper = prod[PROD_W-1:31];
            always_comb
            begin
                if ((&upper) || !(|upper)) begin
                    prod_sat = prod[31:0];
                end else if (prod[PROD_W-1]) begin
                    prod_sat = 32'sh8000_0000;
                end else begin
                    prod_sat = 32'sh7fff_ffff;
                end
            end
        end else begin : g_fit
            assign prod_sat = 32'(prod);
        end
    endgenerate

    // code seven carries no meaning: treat as star
    assign kind_in = (dep_dir == 3'd7) ? dvdp_pkg::KIND_STAR : dep_dir;

    always_comb
    begin
        term.kind     = kind_in;
        term.distance = '0;
        if (coef == '0) begin
            term.kind = dvdp_pkg::KIND_EQ;
        end else if (kind_in == dvdp_pkg::KIND_EXACT) begin
            term.distance = prod_sat;
        end else if (coef[15]) begin
            unique case (kind_in)
                dvdp_pkg::KIND_LT:  term.kind = dvdp_pkg::KIND_GT;
                dvdp_pkg::KIND_GT:  term.kind = dvdp_pkg::KIND_LT;
                dvdp_pkg::KIND_LEQ: term.kind = dvdp_pkg::KIND_GEQ;
                dvdp_pkg::KIND_GEQ: term.kind = dvdp_pkg::KIND_LEQ;
                default:            term.kind = kind_in;
            endcase
        end
    end

endmodule
